### design/msrp_pkg.sv
package msrp_pkg;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_POS    = 3'd1,
    FN_SPIN   = 3'd2,
    FN_CENTER = 3'd3,
    FN_RANGE  = 3'd4
  } func_e;

  // per-channel record held in the state RAM
  typedef struct packed {
    logic [7:0]        cur_angle;
    logic [7:0]        tgt_angle;
    logic [15:0]       ramp_delay;
    logic [7:0]        ramp_step;
    logic              spin_mode;
    logic signed [7:0] spin_speed;
    logic [31:0]       last_step;
    logic [11:0]       center;
    logic [10:0]       range;
  } chan_rec_t;

  localparam int REC_W = $bits(chan_rec_t);

  localparam chan_rec_t RESET_REC = '{
    cur_angle:  8'd90,
    tgt_angle:  8'd90,
    ramp_delay: 16'd15,
    ramp_step:  8'd1,
    spin_mode:  1'b0,
    spin_speed: 8'sd0,
    last_step:  32'd0,
    center:     12'd1500,
    range:      11'd1000
  };

  localparam int unsigned MAX_ANGLE = 180;
  localparam int unsigned MAX_SPEED = 100;
  localparam int unsigned US_MIN    = 500;
  localparam int unsigned US_MAX    = 2500;

  // floor(x/100) = (x*RECIP_100) >> 25, exact for x < 2^18
  localparam logic [18:0] RECIP_100 = 19'd335545;
  localparam int unsigned SH_100    = 25;
  // floor(us*128/625) = (us*RECIP_TK) >> 22, exact for us < 4096
  localparam logic [19:0] RECIP_TK  = 20'd858994;
  localparam int unsigned SH_TK     = 22;
  // floor(x/18) = (x*RECIP_18) >> 17, exact for x < 2^15
  localparam logic [12:0] RECIP_18  = 13'd7282;
  localparam int unsigned SH_18     = 17;

  typedef logic [11:0] ang_tab_t [256];

  function automatic ang_tab_t build_ang_tab();
    ang_tab_t    tab;
    int unsigned aa;
    int unsigned us;
    int unsigned tk;
    for (int a = 0; a < 256; a++) begin
      aa = (a > MAX_ANGLE) ? MAX_ANGLE : a;
      us = 1000 + (aa * 1000) / 180;
      tk = (us * 128) / 625;
      if (tk > 4095) tk = 4095;
      tab[a] = 12'(tk);
    end
    return tab;
  endfunction

  // angle in degrees to PWM off count
  localparam ang_tab_t ANGLE_TICKS = build_ang_tab();

endpackage

### design/multichannel_servo_ramp_pulse.sv
// Multichannel servo pulse controller.
//
// Input channel: an item is taken on a rising edge with start high and busy
// low. func_i selects the command: tick one millisecond, set position (target,
// ramp delay, ramp step), set spin speed, set spin center or set spin range.
// Set commands update one channel's record and give no results; busy is high
// while the record is merged and written back after the item is taken, and the
// next item can be taken once busy falls. Unknown func codes are dropped at
// once and never raise busy.
//
// Result channel: a tick gives one result per channel, channel 0 first, each
// shown for one cycle with out_valid_o high; last_of_run_o marks the final one.
// Each channel passes through three steps (record update, divide-by-100
// multiply, pulse-count multiply); a tick keeps busy high until the last
// channel is done, and each result is registered from its pulse-count step.
// The rate is set by that three-step chain per channel through the record RAM.
//
// Reset: all channel records read as their reset values through per-entry
// valid bits (no clearing pass); the millisecond count returns to zero.
// The receiver cannot stall: every result is taken in the cycle it is shown.
module multichannel_servo_ramp_pulse #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        func_i,
  input  logic [3:0]        channel_i,
  input  logic signed [9:0] angle_i,
  input  logic [15:0]       step_delay_i,
  input  logic [7:0]        step_size_i,
  input  logic signed [8:0] speed_i,
  input  logic [11:0]       center_us_i,
  input  logic [10:0]       range_us_i,
  output logic              out_valid_o,
  output logic [3:0]        out_channel_o,
  output logic [11:0]       pulse_ticks_o,
  output logic              written_o,
  output logic              last_of_run_o
);

  import msrp_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_CHANNELS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EX   = 4'b0010,  // record read back, merge, write
    S_DV   = 4'b0100,  // spin: divide product by 100, clamp pulse
    S_TK   = 4'b1000   // pulse to counts, present result
  } state_e;

  state_e state_q, state_d;

  logic [31:0]       ms_q, ms_d;
  logic [CH_W-1:0]   idx_q, idx_d;
  logic [NUM_CHANNELS-1:0] vld_q;

  // latched command fields
  logic [2:0]        func_q;
  logic signed [9:0] angle_q;
  logic [15:0]       delay_q;
  logic [7:0]        stepsz_q;
  logic signed [8:0] speed_q;
  logic [11:0]       center_in_q;
  logic [10:0]       range_in_q;

  // per-channel pipeline registers
  logic              mode_q;
  logic              due_q;
  logic [11:0]       angt_q;
  logic [17:0]       prod_q;
  logic              neg_q;
  logic [11:0]       center_q;
  logic [11:0]       us_q;

  // result registers
  logic              out_valid_q;
  logic [3:0]        out_ch_q;
  logic [11:0]       out_ticks_q;
  logic              out_wr_q;
  logic              out_last_q;

  logic              accept;
  logic [CH_W-1:0]   ch_eff;
  logic [CH_W-1:0]   raddr;
  logic [REC_W-1:0]  rd_data;
  logic              ram_we;
  chan_rec_t         rec;
  chan_rec_t         new_rec;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // commands beyond the channel count go to channel 0
  assign ch_eff = (32'(channel_i) < NUM_CHANNELS) ? CH_W'(channel_i) : '0;

  // Reads are issued in the cycle before the record is used: on accept for
  // the first entry, and in S_TK for the next channel. The write of an entry
  // always lands before any later read of it, since each entry is written
  // once and busy holds off new items until the write is done.
  always_comb begin
    raddr = idx_q + 1'b1;
    if (state_q == S_IDLE) begin
      raddr = (func_i == FN_TICK) ? '0 : ch_eff;
    end
  end

  assign ram_we = (state_q == S_EX);

  msrp_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (new_rec),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // ---------------- record update ----------------
  logic              due;
  logic [8:0]        up_sum;
  logic [7:0]        dn_diff;
  logic [7:0]        step_cur;
  logic [7:0]        ang_clamp;
  logic [15:0]       delay_fix;
  logic [7:0]        step_fix;
  logic [8:0]        sp_mag;
  logic [24:0]       sp_scaled;
  logic [7:0]        sp_lim;
  logic [6:0]        spd_mag;

  always_comb begin
    rec = vld_q[idx_q] ? chan_rec_t'(rd_data) : RESET_REC;

    due = (ms_q - rec.last_step) >= {16'd0, rec.ramp_delay};

    // one ramp step toward the target, never past it
    up_sum   = {1'b0, rec.cur_angle} + {1'b0, rec.ramp_step};
    dn_diff  = rec.cur_angle - rec.tgt_angle;
    step_cur = rec.cur_angle;
    if (rec.cur_angle < rec.tgt_angle) begin
      step_cur = (up_sum > {1'b0, rec.tgt_angle}) ? rec.tgt_angle : up_sum[7:0];
    end else if (rec.cur_angle > rec.tgt_angle) begin
      step_cur = (rec.ramp_step >= dn_diff) ? rec.tgt_angle
                                            : rec.cur_angle - rec.ramp_step;
    end

    // set-position operands
    if (angle_q < 0) begin
      ang_clamp = 8'd0;
    end else if (angle_q > 10'sd180) begin
      ang_clamp = 8'(MAX_ANGLE);
    end else begin
      ang_clamp = angle_q[7:0];
    end
    delay_fix = (delay_q == 16'd0) ? 16'd1 : delay_q;
    step_fix  = (stepsz_q == 8'd0) ? 8'd1 : stepsz_q;

    // speed beyond 100 percent: round(|s|*5/9), halves away from zero, capped at 100
    sp_mag    = speed_q[8] ? 9'(-speed_q) : 9'(speed_q);
    sp_scaled = ((25'(sp_mag) * 25'd10 + 25'd9) * 25'(RECIP_18)) >> SH_18;
    if (sp_mag <= 9'(MAX_SPEED)) begin
      sp_lim = 8'(sp_mag);
    end else if (sp_scaled > 25'(MAX_SPEED)) begin
      sp_lim = 8'(MAX_SPEED);
    end else begin
      sp_lim = sp_scaled[7:0];
    end

    // stored spin speed lies within +-100
    spd_mag = rec.spin_speed[7] ? 7'(-rec.spin_speed) : 7'(rec.spin_speed);

    new_rec = rec;
    case (func_q)
      FN_TICK: begin
        if (!rec.spin_mode && due) begin
          new_rec.last_step = ms_q;
          new_rec.cur_angle = step_cur;
        end
      end
      FN_POS: begin
        new_rec.spin_mode  = 1'b0;
        new_rec.tgt_angle  = ang_clamp;
        new_rec.ramp_delay = delay_fix;
        new_rec.ramp_step  = step_fix;
      end
      FN_SPIN: begin
        new_rec.spin_mode  = 1'b1;
        new_rec.spin_speed = speed_q[8] ? -$signed(sp_lim) : $signed(sp_lim);
      end
      FN_CENTER: new_rec.center = center_in_q;
      FN_RANGE:  new_rec.range  = range_in_q;
      default:   new_rec = rec;
    endcase
  end

  // ---------------- spin pulse arithmetic ----------------
  logic [36:0]        quot_full;
  logic [10:0]        quot;
  logic signed [13:0] us_raw;
  logic [11:0]        us_clamp;
  logic [31:0]        tk_full;
  logic [11:0]        tk_spin;

  always_comb begin
    quot_full = (37'(prod_q) * 37'(RECIP_100)) >> SH_100;
    quot      = quot_full[10:0];
    us_raw    = neg_q ? $signed({2'b00, center_q}) - $signed({3'b000, quot})
                      : $signed({2'b00, center_q}) + $signed({3'b000, quot});
    if (us_raw < $signed(14'(US_MIN))) begin
      us_clamp = 12'(US_MIN);
    end else if (us_raw > $signed(14'(US_MAX))) begin
      us_clamp = 12'(US_MAX);
    end else begin
      us_clamp = us_raw[11:0];
    end
    tk_full = (32'(us_q) * 32'(RECIP_TK)) >> SH_TK;
    tk_spin = tk_full[11:0];
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    ms_d    = ms_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            FN_TICK: begin
              ms_d    = ms_q + 32'd1;
              idx_d   = '0;
              state_d = S_EX;
            end
            FN_POS, FN_SPIN, FN_CENTER, FN_RANGE: begin
              idx_d   = ch_eff;
              state_d = S_EX;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_EX: state_d = (func_q == FN_TICK) ? S_DV : S_IDLE;
      S_DV: state_d = S_TK;
      S_TK: begin
        if (idx_q == LAST_IDX) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_EX;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ms_q        <= '0;
      idx_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ms_q        <= ms_d;
      idx_q       <= idx_d;
      out_valid_q <= (state_q == S_TK);
      if (ram_we) begin
        vld_q[idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= func_i;
      angle_q     <= angle_i;
      delay_q     <= step_delay_i;
      stepsz_q    <= step_size_i;
      speed_q     <= speed_i;
      center_in_q <= center_us_i;
      range_in_q  <= range_us_i;
    end
    if (state_q == S_EX) begin
      mode_q   <= rec.spin_mode;
      due_q    <= due;
      angt_q   <= ANGLE_TICKS[step_cur];
      prod_q   <= 18'(spd_mag) * 18'(rec.range);
      neg_q    <= rec.spin_speed[7];
      center_q <= rec.center;
    end
    if (state_q == S_DV) begin
      us_q <= us_clamp;
    end
    if (state_q == S_TK) begin
      out_ch_q    <= 4'(idx_q);
      out_wr_q    <= mode_q || due_q;
      out_last_q  <= (idx_q == LAST_IDX);
      if (mode_q) begin
        out_ticks_q <= tk_spin;
      end else begin
        out_ticks_q <= due_q ? angt_q : 12'd0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign pulse_ticks_o = out_ticks_q;
  assign written_o     = out_wr_q;
  assign last_of_run_o = out_last_q;

  // ---------------- checks ----------------
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> busy)
    else $error("result run ended early");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !written_o |-> pulse_ticks_o == 12'd0)
    else $error("unwritten channel carries a pulse");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_run_o |=> !out_valid_o)
    else $error("results continue after last channel");

  a_tk_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TK |=> out_valid_q)
    else $error("channel step lost its result");

endmodule

### design/msrp_ram.sv
module msrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
